FILE: src/djs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djs_pkg
// shared types and the job ordering rule for the deadline job sequencer
// ----------------------------------------------------------------------------
package djs_pkg;

    localparam int WEIGHT_W   = 16;
    localparam int DEADLINE_W = 8;
    localparam int SLOT_OUT_W = 4;
    localparam int SEL_OUT_W  = 5;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0]   weight;
        logic        [DEADLINE_W-1:0] deadline;
    } t_job;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    // higher weight first, later deadline first on a tie
    function automatic logic goes_before(input t_job a, input t_job b);
        logic res;
        if (a.weight != b.weight) begin
            res = (a.weight > b.weight);
        end else begin
            res = (a.deadline > b.deadline);
        end
        return res;
    endfunction

endpackage

FILE: src/djs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djs_cell
// one entry of the insertion sort chain, shifts in on insert, out on pop
// ----------------------------------------------------------------------------
module djs_cell
    import djs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_ins,
    input  logic i_pop,
    input  t_job i_new,
    input  logic i_prev_valid,
    input  t_job i_prev_job,
    input  logic i_prev_before,
    input  logic i_next_valid,
    input  t_job i_next_job,
    output logic o_valid,
    output t_job o_job,
    output logic o_before
);

    logic r_valid;
    logic n_valid;
    t_job r_job;
    t_job n_job;

    assign o_before = !r_valid || goes_before(i_new, r_job);

    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        if (i_ins) begin
            if (i_prev_before) begin
                n_valid = i_prev_valid;
                n_job   = i_prev_job;
            end else if (o_before) begin
                n_valid = 1'b1;
                n_job   = i_new;
            end
        end else if (i_pop) begin
            n_valid = i_next_valid;
            n_job   = i_next_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

FILE: src/djs_slot_alloc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djs_slot_alloc
// slot occupancy and search for the latest free slot below the job's limit
// ----------------------------------------------------------------------------
module djs_slot_alloc
    import djs_pkg::*;
#(
    parameter int MAX_JOBS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic                          i_clear,
    input  logic [DEADLINE_W-1:0]         i_deadline,
    input  logic [$clog2(MAX_JOBS+1)-1:0] i_count,
    output logic                          o_got,
    output logic [$clog2(MAX_JOBS)-1:0]   o_slot
);

    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int SLOT_W = $clog2(MAX_JOBS);
    localparam int CMP_W  = (CNT_W > DEADLINE_W) ? CNT_W : DEADLINE_W;

    logic [MAX_JOBS-1:0] r_taken;
    logic [MAX_JOBS-1:0] n_taken;
    logic [MAX_JOBS-1:0] w_pick;
    logic [CMP_W-1:0]    w_dl;
    logic [CMP_W-1:0]    w_cnt;
    logic [CMP_W-1:0]    w_top;

    assign w_dl  = CMP_W'(i_deadline);
    assign w_cnt = CMP_W'(i_count);
    assign w_top = (w_dl < w_cnt) ? w_dl : w_cnt;

    always_comb begin
        o_got  = 1'b0;
        o_slot = '0;
        w_pick = '0;
        for (int s = 0; s < MAX_JOBS; s++) begin
            if ((CMP_W'(s) < w_top) && !r_taken[s]) begin
                o_got     = 1'b1;
                o_slot    = SLOT_W'(s);
                w_pick    = '0;
                w_pick[s] = 1'b1;
            end
        end
    end

    always_comb begin
        n_taken = r_taken;
        if (i_clear) begin
            n_taken = '0;
        end else if (i_take) begin
            n_taken = r_taken | w_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else begin
            r_taken <= n_taken;
        end
    end

endmodule

FILE: src/deadline_job_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_job_sequencer
// greedy job sequencing with deadlines over a sorted chain of job cells
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready) carries one job per transaction;
//   a job with i_last_job high closes the set and starts scheduling
//   jobs beyond MAX_JOBS are dropped and flag o_overflow for the set
//   each job is sorted into the cell chain as it arrives, one per cycle
//   after the closing job the chain is shifted out from its head, one job a
//   cycle, through the slot search; one result transaction per held job
//   leaves on (o_out_valid / i_out_ready), in sorted order, o_last_result
//   marking the final one
//   the input is closed while the set is emitted; a new set is taken only
//   once the last job of the previous set has left the chain
//   the closing job switches to emit; each pop then loads the head job into
//   the output register; a stalled receiver holds it and pauses the chain
//   reset empties the chain, slot map and counters; no clearing pass
// ----------------------------------------------------------------------------
module deadline_job_sequencer
    import djs_pkg::*;
#(
    parameter int MAX_JOBS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [15:0]      i_job_weight,
    input  logic [7:0]              i_job_deadline,
    input  logic                    i_last_job,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [15:0]      o_out_weight,
    output logic [7:0]              o_out_deadline,
    output logic                    o_is_selected,
    output logic [3:0]              o_slot_index,
    output logic [4:0]              o_selected_count,
    output logic                    o_overflow,
    output logic                    o_last_result
);

    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int SLOT_W = $clog2(MAX_JOBS);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] n_rem;
    logic [CNT_W-1:0] r_sel;
    logic [CNT_W-1:0] n_sel;
    logic             r_ovf;
    logic             n_ovf;
    logic             r_out_valid;
    logic             n_out_valid;

    t_job             r_out_job;
    logic             r_out_got;
    logic [SLOT_W-1:0] r_out_slot;
    logic [CNT_W-1:0] r_out_sel;
    logic             r_out_ovf;
    logic             r_out_last;

    logic             w_accept;
    logic             w_ins;
    logic             w_pop;
    logic             w_done;
    t_job             w_new;
    logic             w_got;
    logic [SLOT_W-1:0] w_slot;

    logic             c_valid  [MAX_JOBS];
    t_job             c_job    [MAX_JOBS];
    logic             c_before [MAX_JOBS];

    assign o_in_ready  = (r_state == ST_LOAD);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_ins       = w_accept && (r_count < CNT_W'(MAX_JOBS));
    assign w_pop       = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign w_done      = w_pop && (r_rem == CNT_W'(1));
    assign w_new.weight   = i_job_weight;
    assign w_new.deadline = i_job_deadline;

    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_chain
        if (g == 0) begin : g_head
            djs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ins        (w_ins),
                .i_pop        (w_pop),
                .i_new        (w_new),
                .i_prev_valid (1'b0),
                .i_prev_job   ('0),
                .i_prev_before(1'b0),
                .i_next_valid (c_valid[1]),
                .i_next_job   (c_job[1]),
                .o_valid      (c_valid[0]),
                .o_job        (c_job[0]),
                .o_before     (c_before[0])
            );
        end else if (g == MAX_JOBS - 1) begin : g_tail
            djs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ins        (w_ins),
                .i_pop        (w_pop),
                .i_new        (w_new),
                .i_prev_valid (c_valid[g-1]),
                .i_prev_job   (c_job[g-1]),
                .i_prev_before(c_before[g-1]),
                .i_next_valid (1'b0),
                .i_next_job   ('0),
                .o_valid      (c_valid[g]),
                .o_job        (c_job[g]),
                .o_before     (c_before[g])
            );
        end else begin : g_mid
            djs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ins        (w_ins),
                .i_pop        (w_pop),
                .i_new        (w_new),
                .i_prev_valid (c_valid[g-1]),
                .i_prev_job   (c_job[g-1]),
                .i_prev_before(c_before[g-1]),
                .i_next_valid (c_valid[g+1]),
                .i_next_job   (c_job[g+1]),
                .o_valid      (c_valid[g]),
                .o_job        (c_job[g]),
                .o_before     (c_before[g])
            );
        end
    end

    djs_slot_alloc #(
        .MAX_JOBS(MAX_JOBS)
    ) u_slot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_pop),
        .i_clear   (w_done),
        .i_deadline(c_job[0].deadline),
        .i_count   (r_count),
        .o_got     (w_got),
        .o_slot    (w_slot)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rem       = r_rem;
        n_sel       = r_sel;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_ins) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_job) begin
                        n_state = ST_EMIT;
                        n_rem   = w_ins ? (r_count + CNT_W'(1)) : r_count;
                        n_sel   = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (w_pop) begin
                    n_out_valid = 1'b1;
                    n_rem       = r_rem - CNT_W'(1);
                    n_sel       = r_sel + CNT_W'(w_got);
                    if (w_done) begin
                        n_state = ST_LOAD;
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_rem       <= '0;
            r_sel       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rem       <= n_rem;
            r_sel       <= n_sel;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // result register, loaded as the head job leaves the chain
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_job  <= c_job[0];
            r_out_got  <= w_got;
            r_out_slot <= w_got ? w_slot : '0;
            r_out_sel  <= r_sel + CNT_W'(w_got);
            r_out_ovf  <= r_ovf;
            r_out_last <= w_done;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_weight     = r_out_job.weight;
    assign o_out_deadline   = r_out_job.deadline;
    assign o_is_selected    = r_out_got;
    assign o_slot_index     = SLOT_OUT_W'(r_out_slot);
    assign o_selected_count = SEL_OUT_W'(r_out_sel);
    assign o_overflow       = r_out_ovf;
    assign o_last_result    = r_out_last;

endmodule
